@@ hdl/rsg_pkg.sv @@
// Package for the stream group reverser: shared types and fixed constants.
// Depends on nothing; used by rsg_store and reverse_stream_in_groups.
package rsg_pkg;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int GSZ_W  = 5;

    // Group size after reset
    localparam logic [GSZ_W-1:0] GSZ_RESET = 5'd3;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    // Flags travelling alongside a buffer read
    typedef struct packed {
        logic list_done;
        logic run_last;
    } t_tag;

endpackage

@@ hdl/rsg_store.sv @@
// Group buffer: one write port, one read port with registered read data.
// The read register holds while no read is issued, so it serves as the output stage.
// Depends on rsg_pkg.
module rsg_store #(
    parameter int MAX_GROUP = 16,
    parameter int AW        = 4
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [rsg_pkg::DATA_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    input  rsg_pkg::t_tag             i_rd_tag,
    output logic [rsg_pkg::DATA_W-1:0] o_rd_data,
    output rsg_pkg::t_tag             o_rd_tag
);
    import rsg_pkg::*;

    logic [DATA_W-1:0] r_mem [MAX_GROUP];
    logic [DATA_W-1:0] r_rd_data;
    t_tag              r_rd_tag;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data and flags registered together
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_tag  <= i_rd_tag;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_tag  = r_rd_tag;

endmodule

@@ hdl/reverse_stream_in_groups.sv @@
// Reverses a stream of signed 32-bit values in groups of group_size. Values are
// collected one per cycle into a MAX_GROUP-entry buffer memory; a full group is then
// read back newest first, one value per cycle while the output is not stalled, and a
// short group closed by end of list is read back in arrival order. Input is stalled
// while a group drains, so no new value is taken until the group has been read out.
// The output register lets the next list value be taken while the last result of a
// group still waits downstream.
// Depends on rsg_pkg and rsg_store.
module reverse_stream_in_groups #(
    parameter int MAX_GROUP = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rsg_pkg::GSZ_W-1:0]   i_cfg_data,
    // input stream
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [rsg_pkg::DATA_W-1:0] i_value,
    input  logic                        i_end_of_list,
    // result stream
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [rsg_pkg::DATA_W-1:0] o_out_value,
    output logic                        o_list_done,
    output logic                        o_run_last
);
    import rsg_pkg::*;

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int KW = (CW > GSZ_W) ? CW : GSZ_W;
    localparam logic [KW-1:0] MAX_K = KW'(MAX_GROUP);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_GROUP);

    t_state            r_state;
    logic [CW-1:0]     r_fill;
    logic [GSZ_W-1:0]  r_gsz;
    logic              r_out_vld;
    logic [AW-1:0]     r_addr;
    logic [CW-1:0]     r_rem;
    logic              r_rev;
    logic              r_eol;

    logic              in_acc;
    logic              rd_en;
    logic              wr_en;
    logic [KW-1:0]     gsz_ext;
    logic [KW-1:0]     eff_k;
    logic [CW-1:0]     n_cnt;
    logic              flush;
    logic [AW-1:0]     n_addr;
    t_tag              rd_tag;
    logic [DATA_W-1:0] rd_data;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign rd_en       = (r_state == S_DRAIN) && (!r_out_vld || !i_stall);

    // Effective group size: zero acts as one, large values saturate
    assign gsz_ext = KW'(r_gsz);
    always_comb begin
        if (r_gsz == '0) begin
            eff_k = KW'(1);
        end else if (gsz_ext > MAX_K) begin
            eff_k = MAX_K;
        end else begin
            eff_k = gsz_ext;
        end
    end

    // Count after this value is stored
    assign wr_en = in_acc && (r_fill < MAX_C);
    assign n_cnt = (r_fill < MAX_C) ? r_fill + CW'(1) : r_fill;
    assign flush = (KW'(n_cnt) >= eff_k) || i_end_of_list;

    // Flags for the value being read
    assign rd_tag.run_last  = (r_rem == CW'(1));
    assign rd_tag.list_done = (r_rem == CW'(1)) && r_eol;

    // Next read address along the drain direction
    assign n_addr = r_rev ? r_addr - AW'(1) : r_addr + AW'(1);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_gsz     <= GSZ_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_gsz <= i_cfg_data;
            end

            // output register occupancy
            if (rd_en) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (flush) begin
                            r_fill  <= '0;
                            r_rem   <= n_cnt;
                            r_eol   <= i_end_of_list;
                            r_state <= S_DRAIN;
                            // full group newest first, short tail oldest first
                            if (KW'(n_cnt) >= eff_k) begin
                                r_rev  <= 1'b1;
                                r_addr <= AW'(n_cnt - CW'(1));
                            end else begin
                                r_rev  <= 1'b0;
                                r_addr <= '0;
                            end
                        end else begin
                            r_fill <= n_cnt;
                        end
                    end
                end
                S_DRAIN: begin
                    // entry was written in an earlier cycle: no forwarding needed
                    if (rd_en) begin
                        r_addr <= n_addr;
                        r_rem  <= r_rem - CW'(1);
                        if (r_rem == CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Buffer memory with registered read, doubling as the result register
    rsg_store #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .i_rd_tag  (rd_tag),
        .o_rd_data (rd_data),
        .o_rd_tag  ({o_list_done, o_run_last})
    );

    assign o_valid     = r_out_vld;
    assign o_out_value = rd_data;

endmodule
